// ===== sv/slm_pkg.sv =====
package slm_pkg;

  // Width of a slot number on the ports and in the stores
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned SLOT_COUNT_DEF = 8;

  typedef enum logic [2:0] {
    OP_ACQ_WR  = 3'd0,
    OP_PUBLISH = 3'd1,
    OP_CANCEL  = 3'd2,
    OP_ACQ_RD  = 3'd3,
    OP_RELEASE = 3'd4
  } slm_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_IGNORED  = 2'd3
  } slm_status_e;

  // Push/pop request into a slot store
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [SLOT_W-1:0] wdata;
  } slm_cmd_t;

  // Store state seen by the control path
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [SLOT_W-1:0] rdata;
  } slm_stat_t;

endpackage

// ===== sv/latest_wins_buffer_slot_manager_core.sv =====
// Latest-wins slot manager: hands frame buffer slot numbers between one producer
// and one consumer. Each input word is one operation (acquire write, publish,
// cancel, acquire read, release) and yields exactly one result word. A new word
// is taken every cycle while in_stall_o is low; it waits in the input register,
// then passes through the decode and the stack/FIFO/mailbox update into the
// result register, where the consumer takes it. A stalled result only holds the
// input register, so throughput stays at one word per cycle whenever the
// consumer takes results. After reset the free FIFO holds every slot in order
// and the block is usable at once; no clearing pass is needed.
module latest_wins_buffer_slot_manager_core #(
  parameter int unsigned SLOT_COUNT = slm_pkg::SLOT_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // operation word in
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 opcode_i,
  input  logic [slm_pkg::SLOT_W-1:0] slot_index_i,
  // result word out
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [slm_pkg::SLOT_W-1:0] granted_index_o,
  output logic                       frame_dropped_o,
  output logic [slm_pkg::SLOT_W-1:0] dropped_index_o
);

  // ---------------- input register ----------------
  logic                       in_valid_q;
  logic [2:0]                 op_q;
  logic [slm_pkg::SLOT_W-1:0] idx_q;
  logic                       advance, fire, in_load;

  // result register free or being drained this cycle
  assign advance    = !out_valid_o || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      op_q  <= opcode_i;
      idx_q <= slot_index_i;
    end
  end

  // ---------------- slot stores ----------------
  slm_pkg::slm_cmd_t  stash_cmd, fifo_cmd;
  slm_pkg::slm_stat_t stash_stat, fifo_stat;

  slm_stash #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_stash (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (stash_cmd),
    .stat_o(stash_stat)
  );

  slm_free_fifo #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_free_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (fifo_cmd),
    .stat_o(fifo_stat)
  );

  // ---------------- mailbox and decode ----------------
  logic                       ready_valid_q, ready_valid_d;
  logic [slm_pkg::SLOT_W-1:0] ready_slot_q, ready_slot_d;
  logic                       in_range;

  slm_pkg::slm_status_e       status_d, status_q;
  logic [slm_pkg::SLOT_W-1:0] granted_d, granted_q;
  logic                       dropped_d, dropped_q;
  logic [slm_pkg::SLOT_W-1:0] dropped_idx_d, dropped_idx_q;

  assign in_range = ({1'b0, idx_q} < (slm_pkg::SLOT_W + 1)'(SLOT_COUNT));

  always_comb begin
    stash_cmd     = '0;
    fifo_cmd      = '0;
    ready_valid_d = ready_valid_q;
    ready_slot_d  = ready_slot_q;
    status_d      = slm_pkg::ST_OK;
    granted_d     = '0;
    dropped_d     = 1'b0;
    dropped_idx_d = '0;

    case (slm_pkg::slm_op_e'(op_q))
      slm_pkg::OP_ACQ_WR: begin
        // reclaimed slots first, they are still warm
        if (!stash_stat.empty) begin
          stash_cmd.pop = fire;
          granted_d     = stash_stat.rdata;
        end else if (!fifo_stat.empty) begin
          fifo_cmd.pop = fire;
          granted_d    = fifo_stat.rdata;
        end else begin
          status_d = slm_pkg::ST_EMPTY;
        end
      end
      slm_pkg::OP_PUBLISH: begin
        if (!in_range) begin
          status_d = slm_pkg::ST_IGNORED;
        end else begin
          if (ready_valid_q) begin
            // unread frame displaced: reclaim it, or lose it if the stack is full
            dropped_d       = 1'b1;
            dropped_idx_d   = ready_slot_q;
            stash_cmd.push  = fire;
            stash_cmd.wdata = ready_slot_q;
            if (stash_stat.full) begin
              status_d = slm_pkg::ST_OVERFLOW;
            end
          end
          ready_valid_d = 1'b1;
          ready_slot_d  = idx_q;
        end
      end
      slm_pkg::OP_CANCEL: begin
        if (!in_range) begin
          status_d = slm_pkg::ST_IGNORED;
        end else if (stash_stat.full) begin
          status_d = slm_pkg::ST_OVERFLOW;
        end else begin
          stash_cmd.push  = fire;
          stash_cmd.wdata = idx_q;
        end
      end
      slm_pkg::OP_ACQ_RD: begin
        if (ready_valid_q) begin
          granted_d     = ready_slot_q;
          ready_valid_d = 1'b0;
        end else begin
          status_d = slm_pkg::ST_EMPTY;
        end
      end
      slm_pkg::OP_RELEASE: begin
        if (!in_range) begin
          status_d = slm_pkg::ST_IGNORED;
        end else if (fifo_stat.full) begin
          status_d = slm_pkg::ST_OVERFLOW;
        end else begin
          fifo_cmd.push  = fire;
          fifo_cmd.wdata = idx_q;
        end
      end
      default: begin
        // unused opcodes: no-op, all-zero result
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_valid_q <= 1'b0;
      ready_slot_q  <= '0;
    end else if (fire) begin
      ready_valid_q <= ready_valid_d;
      ready_slot_q  <= ready_slot_d;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q      <= status_d;
      granted_q     <= granted_d;
      dropped_q     <= dropped_d;
      dropped_idx_q <= dropped_idx_d;
    end
  end

  assign status_o        = status_q;
  assign granted_index_o = granted_q;
  assign frame_dropped_o = dropped_q;
  assign dropped_index_o = dropped_idx_q;

  // ---------------- assertions ----------------
  // a held result must back-pressure a pending word
  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_o && out_stall_i |-> in_stall_o)
    else $error("pending word not stalled behind held result");

  // a processed word always lands in the result register
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed word produced no result");

  // a successful read empties the mailbox
  a_read_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (op_q == slm_pkg::OP_ACQ_RD) && ready_valid_q |=> !ready_valid_q)
    else $error("mailbox still full after acquire read");

  // a slot is only granted with ok status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != slm_pkg::ST_OK) |-> (granted_index_o == '0))
    else $error("slot granted with non-ok status");

  // a drop is only reported by an accepted publish
  a_drop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_dropped_o |->
      (status_o == slm_pkg::ST_OK) || (status_o == slm_pkg::ST_OVERFLOW))
    else $error("drop reported with wrong status");

endmodule

// ===== sv/slm_stash.sv =====
// Producer stack of reclaimed slots (LIFO).
module slm_stash #(
  parameter int unsigned SLOT_COUNT = slm_pkg::SLOT_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slm_pkg::slm_cmd_t  cmd_i,
  output slm_pkg::slm_stat_t stat_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);

  logic [slm_pkg::SLOT_W-1:0] entries_q [SLOT_COUNT];
  logic [CntW-1:0]            count_q, count_d;
  logic [CntW-1:0]            top_cnt;
  logic [IdxW-1:0]            top_idx;
  logic [IdxW-1:0]            wr_idx;

  assign top_cnt = count_q - CntW'(1);
  assign top_idx = top_cnt[IdxW-1:0];
  assign wr_idx  = count_q[IdxW-1:0];

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(SLOT_COUNT));
  assign stat_o.rdata = entries_q[top_idx];

  always_comb begin
    count_d = count_q;
    if (cmd_i.push && !stat_o.full) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop && !stat_o.empty) begin
      count_d = top_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // entries below the count are always written before they are read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !stat_o.full) begin
      entries_q[wr_idx] <= cmd_i.wdata;
    end
  end

endmodule

// ===== sv/slm_free_fifo.sv =====
// Free slot FIFO, full with slots 0..SLOT_COUNT-1 after reset.
module slm_free_fifo #(
  parameter int unsigned SLOT_COUNT = slm_pkg::SLOT_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slm_pkg::slm_cmd_t  cmd_i,
  output slm_pkg::slm_stat_t stat_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);

  logic [slm_pkg::SLOT_W-1:0] entries_q [SLOT_COUNT];
  logic [IdxW-1:0]            head_q, tail_q;
  logic [CntW-1:0]            count_q;
  logic                       do_push, do_pop;

  function automatic logic [IdxW-1:0] ptr_next(input logic [IdxW-1:0] p);
    logic [IdxW-1:0] r;
    if (p == IdxW'(SLOT_COUNT - 1)) begin
      r = '0;
    end else begin
      r = p + IdxW'(1);
    end
    return r;
  endfunction

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(SLOT_COUNT));
  assign stat_o.rdata = entries_q[head_q];

  assign do_push = cmd_i.push && !stat_o.full;
  assign do_pop  = cmd_i.pop && !stat_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= CntW'(SLOT_COUNT);
      for (int i = 0; i < SLOT_COUNT; i++) begin
        entries_q[i] <= slm_pkg::SLOT_W'(i);
      end
    end else begin
      if (do_push) begin
        entries_q[tail_q] <= cmd_i.wdata;
        tail_q            <= ptr_next(tail_q);
        count_q           <= count_q + CntW'(1);
      end else if (do_pop) begin
        head_q  <= ptr_next(head_q);
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== tb/tb_latest_wins_buffer_slot_manager_core.sv =====
`timescale 1ns / 1ps

module tb_latest_wins_buffer_slot_manager_core;
  import slm_pkg::*;

  localparam int SLOTS          = SLOT_COUNT_DEF;
  localparam int RANDOM_WORDS   = 1320;
  localparam int HOLD_CYCLES    = 96;    // long consumer hold-off, fills the pipe
  localparam int DRAIN_CYCLES   = 8;     // margin after the last result is taken
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no word moving on either side

  // codes 5..7 are not operations: the block must answer ok with zeros
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]        op;
    logic [SLOT_W-1:0] idx;
  } op_word_t;

  typedef struct packed {
    slm_status_e       status;
    logic [SLOT_W-1:0] granted;
    logic              dropped;
    logic [SLOT_W-1:0] dropped_idx;
  } result_word_t;

  typedef struct {
    op_word_t     w;
    bit           typed;
    result_word_t res;
  } plan_row_t;

  typedef enum {MIX_FLOW, MIX_HOARD, MIX_NOISE} traffic_mix_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        opcode_i;
  logic [SLOT_W-1:0] slot_index_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        status_o;
  logic [SLOT_W-1:0] granted_index_o;
  logic              frame_dropped_o;
  logic [SLOT_W-1:0] dropped_index_o;

  latest_wins_buffer_slot_manager_core #(.SLOT_COUNT(SLOTS)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .slot_index_i    (slot_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .granted_index_o (granted_index_o),
    .frame_dropped_o (frame_dropped_o),
    .dropped_index_o (dropped_index_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Slot pool mirror: reclaim stack, free FIFO and the mailbox
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0] reclaim_stack [SLOTS];
  int                reclaim_depth;
  logic [SLOT_W-1:0] spare_slots [SLOTS];
  int                free_rd, free_wr, free_cnt;
  logic              mbox_full;
  logic [SLOT_W-1:0] mbox_slot;

  function automatic int ring_next(int p);
    return (p + 1 >= SLOTS) ? 0 : p + 1;
  endfunction

  // Applies one operation to the mirror and returns the word the block must give
  function automatic result_word_t predict_slot_op(op_word_t w);
    result_word_t r;
    bit           in_range;
    r        = '{status: ST_OK, granted: '0, dropped: 1'b0, dropped_idx: '0};
    in_range = (int'(w.idx) < SLOTS);
    case (w.op)
      OP_ACQ_WR: begin
        if (reclaim_depth > 0) begin
          reclaim_depth--;
          r.granted = reclaim_stack[reclaim_depth];
        end else if (free_cnt > 0) begin
          r.granted = spare_slots[free_rd];
          free_rd   = ring_next(free_rd);
          free_cnt--;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      OP_PUBLISH: begin
        if (!in_range) begin
          r.status = ST_IGNORED;
        end else begin
          if (mbox_full) begin
            r.dropped     = 1'b1;
            r.dropped_idx = mbox_slot;
            // displaced slot is lost when the stack has no room
            if (reclaim_depth < SLOTS) begin
              reclaim_stack[reclaim_depth] = mbox_slot;
              reclaim_depth++;
            end else begin
              r.status = ST_OVERFLOW;
            end
          end
          mbox_slot = w.idx;
          mbox_full = 1'b1;
        end
      end
      OP_CANCEL: begin
        if (!in_range) begin
          r.status = ST_IGNORED;
        end else if (reclaim_depth >= SLOTS) begin
          r.status = ST_OVERFLOW;
        end else begin
          reclaim_stack[reclaim_depth] = w.idx;
          reclaim_depth++;
        end
      end
      OP_ACQ_RD: begin
        if (mbox_full) begin
          r.granted = mbox_slot;
          mbox_full = 1'b0;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      OP_RELEASE: begin
        if (!in_range) begin
          r.status = ST_IGNORED;
        end else if (free_cnt >= SLOTS) begin
          r.status = ST_OVERFLOW;
        end else begin
          spare_slots[free_wr] = w.idx;
          free_wr = ring_next(free_wr);
          free_cnt++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  result_word_t      pending_results[$];
  plan_row_t         directed_plan[$];
  logic [SLOT_W-1:0] producer_held[$];
  logic [SLOT_W-1:0] consumer_held[$];
  int                mismatch_count;
  int                idle_cycles;
  bit                hold_on;

  function automatic void plan_row(logic [2:0] op, logic [SLOT_W-1:0] idx, bit typed,
                                   slm_status_e st = ST_OK, logic [SLOT_W-1:0] gr = '0,
                                   logic dr = 1'b0, logic [SLOT_W-1:0] di = '0);
    plan_row_t row;
    row.w     = '{op: op, idx: idx};
    row.typed = typed;
    row.res   = '{status: st, granted: gr, dropped: dr, dropped_idx: di};
    directed_plan.push_back(row);
  endfunction

  function automatic logic [SLOT_W-1:0] take_held(ref logic [SLOT_W-1:0] q[$]);
    int                i;
    logic [SLOT_W-1:0] s;
    i = $urandom_range(0, q.size() - 1);
    s = q[i];
    q.delete(i);
    return s;
  endfunction

  // Producer/consumer traffic: mostly legal use of held slots, some abuse
  function automatic op_word_t next_word(traffic_mix_e mix);
    op_word_t w;
    int       pick;
    pick  = $urandom_range(0, 99);
    w.op  = OP_ACQ_WR;
    w.idx = SLOT_W'($urandom_range(0, 15));
    if (mix == MIX_NOISE || (mix == MIX_FLOW && pick >= 95)) begin
      w.op = 3'($urandom_range(0, 7));
    end else if (mix == MIX_HOARD) begin
      if (pick >= 80) begin
        w.op  = OP_PUBLISH;
        w.idx = producer_held.size() ? take_held(producer_held)
                                     : SLOT_W'($urandom_range(0, SLOTS - 1));
      end else if (pick >= 50) begin
        w.op  = OP_CANCEL;
        w.idx = producer_held.size() ? take_held(producer_held)
                                     : SLOT_W'($urandom_range(0, SLOTS - 1));
      end
    end else begin
      if (pick >= 25 && pick < 50 && producer_held.size()) begin
        w.op  = OP_PUBLISH;
        w.idx = take_held(producer_held);
      end else if (pick >= 50 && pick < 58 && producer_held.size()) begin
        w.op  = OP_CANCEL;
        w.idx = take_held(producer_held);
      end else if (pick >= 58 && pick < 80) begin
        w.op = OP_ACQ_RD;
      end else if (pick >= 80) begin
        if (consumer_held.size()) begin
          w.op  = OP_RELEASE;
          w.idx = take_held(consumer_held);
        end else begin
          w.op = OP_ACQ_RD;
        end
      end
    end
    return w;
  endfunction

  task automatic issue_word(input op_word_t w, input bit typed, input result_word_t typed_res,
                            input bit gapless, output result_word_t pred);
    int gap;
    gap = (gapless || hold_on) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= w.op;
    slot_index_i <= w.idx;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_slot_op(w);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  initial begin
    traffic_mix_e mix;
    op_word_t     w;
    result_word_t pred;
    bit           gapless;
    int           burst_left;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = '0;
    slot_index_i   = '0;
    mismatch_count = 0;
    hold_on        = 1'b0;

    reclaim_depth = 0;
    for (int i = 0; i < SLOTS; i++) begin
      reclaim_stack[i] = '0;
      spare_slots[i]   = SLOT_W'(i);
    end
    free_rd   = 0;
    free_wr   = 0;
    free_cnt  = SLOTS;
    mbox_full = 1'b0;
    mbox_slot = '0;

    // directed: FIFO full on release, bad indices, unused code, drain the pool
    // until acquire fails, fill the stack until cancel and publish overflow
    plan_row(OP_RELEASE, 4'd0,  1'b1, ST_OVERFLOW);
    plan_row(OP_UNUSED,  4'd15, 1'b1, ST_OK);
    plan_row(OP_PUBLISH, 4'd15, 1'b1, ST_IGNORED);
    plan_row(OP_CANCEL,  4'd8,  1'b1, ST_IGNORED);
    plan_row(OP_RELEASE, 4'd12, 1'b1, ST_IGNORED);
    for (int i = 0; i < SLOTS; i++)
      plan_row(OP_ACQ_WR, (i % 2) ? 4'd15 : 4'd0, 1'b1, ST_OK, SLOT_W'(i));
    plan_row(OP_ACQ_WR,  4'd9,  1'b1, ST_EMPTY);
    for (int i = SLOTS - 1; i >= 0; i--)
      plan_row(OP_CANCEL, SLOT_W'(i), 1'b0);
    plan_row(OP_CANCEL,  4'd5,  1'b1, ST_OVERFLOW);
    plan_row(OP_PUBLISH, 4'd2,  1'b1, ST_OK);
    plan_row(OP_PUBLISH, 4'd3,  1'b1, ST_OVERFLOW, 4'd0, 1'b1, 4'd2);
    plan_row(OP_ACQ_RD,  4'd0,  1'b1, ST_OK, 4'd3);
    plan_row(OP_ACQ_RD,  4'd0,  1'b1, ST_EMPTY);
    plan_row(OP_RELEASE, 4'd3,  1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i])
      issue_word(directed_plan[i].w, directed_plan[i].typed, directed_plan[i].res, 1'b0, pred);

    // the directed part leaves slot 3 free and the stack full; the producer holds nothing
    burst_left = 0;
    mix        = MIX_FLOW;
    gapless    = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(16, 48);
        case ($urandom_range(0, 9))
          7, 8:    mix = MIX_HOARD;
          9:       mix = MIX_NOISE;
          default: mix = MIX_FLOW;
        endcase
        gapless = ($urandom_range(0, 3) == 0);
      end
      burst_left--;
      w = next_word(mix);
      issue_word(w, 1'b0, '0, gapless, pred);
      if (pred.status == ST_OK && w.op == OP_ACQ_WR) producer_held.push_back(pred.granted);
      if (pred.status == ST_OK && w.op == OP_ACQ_RD) consumer_held.push_back(pred.granted);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Consumer side: random stalls per word, two long hold-offs
  // ---------------------------------------------------------------------------
  initial begin
    int taken;
    int wait_n;
    bit calm;
    out_stall_i = 1'b0;
    taken       = 0;
    calm        = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == 400 || taken == 1000) begin
        hold_on = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_on = 1'b0;
      end else begin
        wait_n = calm ? 0 : $urandom_range(0, 16);
        if (wait_n > 0) begin
          out_stall_i <= 1'b1;
          repeat (wait_n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    result_word_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending, status", status_o, 0);
      end else begin
        exp_res = pending_results.pop_front();
        if (status_o !== exp_res.status)
          report_mismatch("status", status_o, exp_res.status);
        if (granted_index_o !== exp_res.granted)
          report_mismatch("granted_index", granted_index_o, exp_res.granted);
        if (frame_dropped_o !== exp_res.dropped)
          report_mismatch("frame_dropped", frame_dropped_o, exp_res.dropped);
        if (dropped_index_o !== exp_res.dropped_idx)
          report_mismatch("dropped_index", dropped_index_o, exp_res.dropped_idx);
      end
    end
  end

  // nothing moving on either side for too long means a hang
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
